FILE: design/b64sc_pkg.sv
`timescale 1ns / 1ps

package b64sc_pkg;

	localparam int unsigned NUM_SLOTS = 4;

	// job queue between front and back; a power of two so the pointers wrap
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CH_PAD   = 8'h3d;  // '='
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5a;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7a;
	localparam logic [7:0] CH_DIG_0 = 8'h30;
	localparam logic [7:0] CH_DIG_9 = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_SLASH = 8'h2f;

	localparam logic [0:63][7:0] B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	// One queued job: all results caused by one input word.
	typedef struct packed {
		logic [NUM_SLOTS-1:0][7:0] slots;
		logic [1:0]                last_idx;
		logic                      byte_valid;
		logic                      eom;
		logic                      bad;
	} b64sc_job_t;

	function automatic logic [7:0] enc_char(input logic [5:0] v);
		enc_char = B64_ALPHABET[v];
	endfunction

	// Bit 6 set: not in the alphabet.
	function automatic logic [6:0] dec_value(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		dec_value = 7'h40;
		case (c) inside
			[CH_UP_A:CH_UP_Z]: begin
				d = c - CH_UP_A;
				dec_value = {1'b0, d[5:0]};
			end
			[CH_LO_A:CH_LO_Z]: begin
				d = c - CH_LO_A + 8'd26;
				dec_value = {1'b0, d[5:0]};
			end
			[CH_DIG_0:CH_DIG_9]: begin
				d = c - CH_DIG_0 + 8'd52;
				dec_value = {1'b0, d[5:0]};
			end
			CH_PLUS:  dec_value = 7'd62;
			CH_SLASH: dec_value = 7'd63;
			default:  dec_value = 7'h40;
		endcase
	endfunction

endpackage

FILE: design/b64sc_if.sv
`timescale 1ns / 1ps

interface b64sc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_message;
	modport source(output valid, data_byte, end_of_message, input ready);
	modport sink(input valid, data_byte, end_of_message, output ready);
endinterface

interface b64sc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       run_last;
	logic       message_done;
	logic       bad_input;
	modport source(output valid, out_byte, byte_valid, run_last, message_done, bad_input,
		input ready);
	modport sink(input valid, out_byte, byte_valid, run_last, message_done, bad_input,
		output ready);
endinterface

interface b64sc_cfg_if;
	logic valid;
	logic ready;
	logic direction;
	modport source(output valid, direction, input ready);
	modport sink(input valid, direction, output ready);
endinterface

FILE: design/b64sc_front.sv
`timescale 1ns / 1ps

module b64sc_front
	import b64sc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	b64sc_in_if.sink   item,
	b64sc_cfg_if.sink  cfg,
	output logic       push_valid,
	input  logic       push_ready,
	output b64sc_job_t push_job
);

	logic        dir_q;
	logic [11:0] acc_q;
	logic [3:0]  pend_q;
	logic [1:0]  chars_q;
	logic        pad_q;
	logic        err_q;

	logic [11:0] acc_d;
	logic [3:0]  pend_d;
	logic [1:0]  chars_d;
	logic        pad_d;
	logic        err_d;

	// encode path
	logic [11:0] acc_e;
	logic [3:0]  p_e;
	logic [3:0]  rem_e;
	logic [5:0]  ch0;
	logic [5:0]  ch1;
	logic [1:0]  nch;
	logic [1:0]  cm;
	logic [1:0]  pads;
	logic [2:0]  total;

	// decode path
	logic [6:0]  dv;
	logic [11:0] acc_dd;
	logic [3:0]  p_d;
	logic [7:0]  dbyte;
	logic        has_byte;

	logic        take;

	assign item.ready = push_ready;
	assign cfg.ready  = 1'b1;
	assign push_valid = item.valid;
	assign take       = item.valid && push_ready;

	always_comb begin
		acc_d    = acc_q;
		pend_d   = pend_q;
		chars_d  = chars_q;
		pad_d    = pad_q;
		err_d    = err_q;
		push_job = '0;

		acc_e = {acc_q[3:0], item.data_byte};
		p_e   = pend_q + 4'd8;
		ch1   = 6'd0;
		nch   = 2'd1;
		case (p_e)
			4'd12: begin
				ch0   = acc_e[11:6];
				ch1   = acc_e[5:0];
				nch   = 2'd2;
				rem_e = 4'd0;
			end
			4'd10: begin
				ch0   = acc_e[9:4];
				rem_e = 4'd4;
			end
			default: begin
				ch0   = acc_e[7:2];
				rem_e = 4'd2;
			end
		endcase
		if (item.end_of_message && rem_e != 4'd0) begin
			ch1 = (rem_e == 4'd4) ? {acc_e[3:0], 2'b00} : {acc_e[1:0], 4'b0000};
			nch = 2'd2;
		end
		cm    = chars_q + nch;
		pads  = item.end_of_message ? (2'd0 - cm) : 2'd0;
		total = {1'b0, nch} + {1'b0, pads};

		dv       = dec_value(item.data_byte);
		acc_dd   = {acc_q[5:0], dv[5:0]};
		p_d      = pend_q + 4'd6;
		has_byte = 1'b0;
		dbyte    = 8'h00;

		if (dir_q == DIR_ENCODE) begin
			acc_d   = acc_e;
			pend_d  = rem_e;
			chars_d = cm;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				push_job.slots[i] = (i < int'(nch)) ? ((i == 0) ? enc_char(ch0) : enc_char(ch1))
					: CH_PAD;
			end
			push_job.last_idx   = 2'(total - 3'd1);
			push_job.byte_valid = 1'b1;
		end else begin
			if (!pad_q && !err_q) begin
				if (item.data_byte == CH_PAD) begin
					pad_d = 1'b1;
				end else if (dv[6]) begin
					err_d = 1'b1;
				end else begin
					acc_d = acc_dd;
					case (p_d)
						4'd8: begin
							dbyte    = acc_dd[7:0];
							has_byte = 1'b1;
							pend_d   = 4'd0;
						end
						4'd10: begin
							dbyte    = acc_dd[9:2];
							has_byte = 1'b1;
							pend_d   = 4'd2;
						end
						4'd12: begin
							dbyte    = acc_dd[11:4];
							has_byte = 1'b1;
							pend_d   = 4'd4;
						end
						default: pend_d = p_d;
					endcase
				end
			end
			push_job.slots[0]   = dbyte;
			push_job.last_idx   = 2'd0;
			push_job.byte_valid = has_byte;
			push_job.bad        = item.end_of_message && err_d;
		end
		push_job.eom = item.end_of_message;

		if (item.end_of_message) begin
			acc_d   = '0;
			pend_d  = '0;
			chars_d = '0;
			pad_d   = 1'b0;
			err_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q   <= DIR_ENCODE;
			acc_q   <= '0;
			pend_q  <= '0;
			chars_q <= '0;
			pad_q   <= 1'b0;
			err_q   <= 1'b0;
		end else if (cfg.valid) begin
			dir_q   <= cfg.direction;
			acc_q   <= '0;
			pend_q  <= '0;
			chars_q <= '0;
			pad_q   <= 1'b0;
			err_q   <= 1'b0;
		end else if (take) begin
			acc_q   <= acc_d;
			pend_q  <= pend_d;
			chars_q <= chars_d;
			pad_q   <= pad_d;
			err_q   <= err_d;
		end
	end

endmodule

FILE: design/b64sc_queue.sv
`timescale 1ns / 1ps

module b64sc_queue
	import b64sc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  b64sc_job_t push_job,
	output logic       head_valid,
	input  logic       pop,
	output b64sc_job_t head_job
);

	b64sc_job_t          mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q;
	logic [QUEUE_AW-1:0] rd_q;
	logic [QUEUE_AW:0]   cnt_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (cnt_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + QUEUE_AW'(1);
			if (do_pop)  rd_q <= rd_q + QUEUE_AW'(1);
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + (QUEUE_AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QUEUE_AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: design/b64sc_back.sv
`timescale 1ns / 1ps

module b64sc_back
	import b64sc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  b64sc_job_t  head_job,
	output logic        pop,
	b64sc_out_if.source result
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic       load;
	logic       is_last;

	logic [7:0] byte_q;
	logic       bval_q;
	logic       last_q;
	logic       done_q;
	logic       bad_q;

	assign load    = head_valid && (!valid_q || result.ready);
	assign is_last = (idx_q == head_job.last_idx);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head_job.slots[idx_q];
			bval_q <= head_job.byte_valid;
			last_q <= is_last;
			done_q <= is_last && head_job.eom;
			bad_q  <= is_last && head_job.bad;
		end
	end

	assign result.valid        = valid_q;
	assign result.out_byte     = byte_q;
	assign result.byte_valid   = bval_q;
	assign result.run_last     = last_q;
	assign result.message_done = done_q;
	assign result.bad_input    = bad_q;

endmodule

FILE: design/base64_stream_codec_unit.sv
`timescale 1ns / 1ps

// channel | dir | payload                                   | word
// item    | in  | data_byte[7:0], end_of_message            | one byte or character
// result  | out | out_byte[7:0], byte_valid, run_last,      | one result
//         |     | message_done, bad_input                   |
// cfg     | in  | direction (0 encode, 1 decode)            | one register write
//
// Front accepts one item word per cycle while the 4-entry job queue has room.
// Back emits one result per cycle while ready is high: decode 1 per item,
// encode 1..4 (chars plus '=' pads), 4 per 3 bytes in a long message. Items
// pass the queue, then the output register. arst_n clears direction, message
// state, queue pointers and output valid. A stalled result never blocks
// intake until the queue fills; cfg is always ready and clears message state.

module base64_stream_codec_unit
	import b64sc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	b64sc_in_if.sink    item,
	b64sc_out_if.source result,
	b64sc_cfg_if.sink   cfg
);

	// front -> queue
	logic       push_valid;
	logic       push_ready;
	b64sc_job_t push_job;

	// queue -> back
	logic       head_valid;
	logic       pop;
	b64sc_job_t head_job;

	// classify the word, update bit state, build the full result list
	b64sc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	// decouples intake from output stalls
	b64sc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.head_valid (head_valid),
		.pop        (pop),
		.head_job   (head_job)
	);

	// walks the job's slots into the registered output
	b64sc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.result     (result)
	);

endmodule

FILE: verif/b64sc_checker.sv
`timescale 1ns / 1ps

module b64sc_checker
	import b64sc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	b64sc_in_if   item,
	b64sc_out_if  result,
	b64sc_cfg_if  cfg,
	output int    fail_count,
	output int    words_outstanding
);

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       message_done;
		logic       bad_input;
	} codec_word_t;

	codec_word_t expected_words[$];
	codec_word_t got_word;
	codec_word_t want_word;
	int          n_fail;

	logic        mode;
	logic [11:0] bit_acc;
	logic [3:0]  acc_bits;
	logic [1:0]  chars_mod4;
	logic        pad_hit;
	logic        bad_hit;

	task automatic clear_message_state();
		bit_acc    = '0;
		acc_bits   = '0;
		chars_mod4 = '0;
		pad_hit    = 1'b0;
		bad_hit    = 1'b0;
	endtask

	function automatic codec_word_t data_word(input logic [7:0] v);
		codec_word_t w;
		w = '0;
		w.out_byte   = v;
		w.byte_valid = 1'b1;
		return w;
	endfunction

	// 6-bit value of a text character, bit 6 set when not in the alphabet
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h40;
		if (c >= CH_UP_A && c <= CH_UP_Z)
			d = c - CH_UP_A;
		else if (c >= CH_LO_A && c <= CH_LO_Z)
			d = c - CH_LO_A + 8'd26;
		else if (c >= CH_DIG_0 && c <= CH_DIG_9)
			d = c - CH_DIG_0 + 8'd52;
		else if (c == CH_PLUS)
			d = 8'd62;
		else if (c == CH_SLASH)
			d = 8'd63;
		return d[6:0];
	endfunction

	task automatic predict_word(input logic [7:0] b, input logic eom);
		codec_word_t w [0:3];
		int          n;
		logic [11:0] sh;
		logic [6:0]  v;
		n = 0;
		if (mode == DIR_ENCODE) begin
			bit_acc  = {bit_acc[3:0], b};
			acc_bits = acc_bits + 4'd8;
			while (acc_bits >= 4'd6) begin
				sh = bit_acc >> (acc_bits - 4'd6);
				w[n] = data_word(B64_ALPHABET[sh[5:0]]);
				n++;
				chars_mod4 = chars_mod4 + 2'd1;
				acc_bits = acc_bits - 4'd6;
			end
			if (eom) begin
				// flush with zero fill, then pad to a group of four
				if (acc_bits != 4'd0) begin
					sh = bit_acc << (4'd6 - acc_bits);
					w[n] = data_word(B64_ALPHABET[sh[5:0]]);
					n++;
					chars_mod4 = chars_mod4 + 2'd1;
				end
				while (chars_mod4 != 2'd0) begin
					w[n] = data_word(CH_PAD);
					n++;
					chars_mod4 = chars_mod4 + 2'd1;
				end
			end
		end else if (!pad_hit && !bad_hit) begin
			if (b == CH_PAD) begin
				pad_hit = 1'b1;
			end else begin
				v = sextet_of(b);
				if (v[6]) begin
					bad_hit = 1'b1;
				end else begin
					bit_acc  = {bit_acc[5:0], v[5:0]};
					acc_bits = acc_bits + 4'd6;
					if (acc_bits >= 4'd8) begin
						sh = bit_acc >> (acc_bits - 4'd8);
						w[n] = data_word(sh[7:0]);
						n++;
						acc_bits = acc_bits - 4'd8;
					end
				end
			end
		end
		if (n == 0) begin
			w[0] = '0;
			n = 1;
		end
		w[n-1].run_last = 1'b1;
		if (eom) begin
			w[n-1].message_done = 1'b1;
			w[n-1].bad_input    = (mode == DIR_DECODE) && bad_hit;
			clear_message_state();
		end
		for (int i = 0; i < n; i++)
			expected_words.insert(expected_words.size(), w[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = DIR_ENCODE;
			clear_message_state();
			expected_words.delete();
			n_fail = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				mode = cfg.direction;
				clear_message_state();
			end
			if (item.valid && item.ready)
				predict_word(item.data_byte, item.end_of_message);
			if (result.valid && result.ready) begin
				got_word = '{result.out_byte, result.byte_valid, result.run_last,
					result.message_done, result.bad_input};
				if (expected_words.size() == 0) begin
					if (n_fail < 10)
						$display("%t unexpected word: byte %h v%b l%b d%b e%b", $realtime,
							got_word.out_byte, got_word.byte_valid, got_word.run_last,
							got_word.message_done, got_word.bad_input);
					n_fail++;
				end else begin
					want_word = expected_words.pop_front();
					if (got_word !== want_word) begin
						if (n_fail < 10)
							$display("%t mismatch: exp %h v%b l%b d%b e%b, got %h v%b l%b d%b e%b",
								$realtime, want_word.out_byte, want_word.byte_valid,
								want_word.run_last, want_word.message_done, want_word.bad_input,
								got_word.out_byte, got_word.byte_valid, got_word.run_last,
								got_word.message_done, got_word.bad_input);
						n_fail++;
					end
				end
			end
		end
		fail_count        <= n_fail;
		words_outstanding <= expected_words.size();
	end

endmodule

FILE: verif/tb_base64_stream_codec_unit.sv
`timescale 1ns / 1ps

module tb_base64_stream_codec_unit
	import b64sc_pkg::*;
();

	// directed words plus random words before the run winds down
	localparam int DIRECTED_WORDS = 26;
	localparam int RANDOM_WORDS   = 330;
	localparam int PHASE_WORDS    = 40;

	logic clk;
	logic arst_n;

	int idle_pct  = 0;  // sender: chance per cycle of holding valid low
	int stall_pct = 0;  // receiver: chance per cycle of holding ready low
	int words_sent = 0;
	int fails;
	int outstanding;

	b64sc_in_if  in_ch();
	b64sc_out_if out_ch();
	b64sc_cfg_if cfg_ch();

	base64_stream_codec_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_ch),
		.result (out_ch),
		.cfg    (cfg_ch)
	);

	// watches all three channels, predicts and compares
	b64sc_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.item              (in_ch),
		.result            (out_ch),
		.cfg               (cfg_ch),
		.fail_count        (fails),
		.words_outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// result side backpressure, redrawn every cycle
	always @(posedge clk)
		out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

	// hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("base64_stream_codec_unit regression: fail");
		$finish;
	end

	// Offer one input word, with random idle cycles ahead of it. Returns just
	// after the accepting edge with valid still high, so the next call can
	// keep it high for back-to-back words.
	task automatic send_word(input logic [7:0] b, input logic eom);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid          <= 1'b1;
		in_ch.data_byte      <= b;
		in_ch.end_of_message <= eom;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic send_text(input string s, input logic eom_at_end);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], eom_at_end && (i == s.len() - 1));
	endtask

	// Stop sending and wait until every predicted word has come out.
	// First edge lets the checker count the last accepted word.
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// only called with the block idle
	task automatic write_direction(input logic d);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.direction <= d;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// encode mode: a message of random raw bytes
	task automatic send_byte_message();
		int len;
		len = $urandom_range(1, 7);
		for (int i = 0; i < len; i++)
			send_word(8'($urandom_range(0, 255)), i == len - 1);
	endtask

	// Decode mode: mostly well-formed text (groups of four, optional '='
	// padding), some with one character damaged or junk after the pad,
	// and some pure noise.
	task automatic send_text_message();
		logic [7:0] msg [0:15];
		logic [5:0] sx;
		int         len;
		int         kind;
		int         pads;
		kind = $urandom_range(0, 99);
		if (kind < 15) begin
			len = $urandom_range(1, 6);
			for (int i = 0; i < len; i++)
				msg[i] = 8'($urandom_range(0, 255));
		end else begin
			len = 4 * $urandom_range(1, 3);
			for (int i = 0; i < len; i++) begin
				sx = 6'($urandom_range(0, 63));
				msg[i] = B64_ALPHABET[sx];
			end
			pads = $urandom_range(0, 2);
			for (int i = 0; i < pads; i++)
				msg[len-1-i] = CH_PAD;
			if (kind >= 80)
				msg[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
			if (pads != 0 && $urandom_range(0, 3) == 0) begin
				msg[len] = 8'($urandom_range(0, 255));
				len++;
			end
		end
		for (int i = 0; i < len; i++)
			send_word(msg[i], i == len - 1);
	endtask

	initial begin
		int   phase;
		int   phase_start;
		logic paused;
		logic phase_dir;

		// input side known from time zero, result ready from the first edge
		arst_n               = 1'b0;
		in_ch.valid          = 1'b0;
		in_ch.data_byte      = 8'h00;
		in_ch.end_of_message = 1'b0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.direction     = DIR_ENCODE;
		paused               = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed: encode ----
		write_direction(DIR_ENCODE);
		send_word(8'h00, 1'b1);   // single zero byte, two pads
		send_word(8'hff, 1'b0);   // all ones, then one pad
		send_word(8'h80, 1'b1);
		send_text("Man", 1'b1);   // full group, no padding
		send_word(8'hff, 1'b0);   // left open, dropped by the write below
		send_word(8'h01, 1'b0);
		drain();

		// ---- directed: decode ----
		write_direction(DIR_DECODE);
		send_text("Zaz0", 1'b1);  // alphabet range ends
		send_text("QQ=*", 1'b1);  // junk after '=' is ignored
		send_text("Q*Q", 1'b1);   // bad char: sticky error, flagged at end
		send_word(8'h00, 1'b1);   // zero byte is outside the alphabet
		send_text("+/9A", 1'b1);
		send_text("TW", 1'b0);    // open message abandoned by mode change
		drain();
		write_direction(DIR_ENCODE);

		// ---- random phases: both directions across all idle mixes ----
		phase = 0;
		while (words_sent < DIRECTED_WORDS + RANDOM_WORDS) begin
			drain();
			phase_dir = (phase % 2 == 1) ? DIR_DECODE : DIR_ENCODE;
			write_direction(phase_dir);
			case ((phase / 2) % 4)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 68;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 68;
				end
				default: begin
					idle_pct  = 7;
					stall_pct = 7;
				end
			endcase
			phase_start = words_sent;
			while (words_sent - phase_start < PHASE_WORDS) begin
				// one full stop mid-phase until the block runs dry
				if (phase == 3 && !paused && words_sent - phase_start >= 20) begin
					drain();
					paused = 1'b1;
				end
				if (phase_dir == DIR_DECODE)
					send_text_message();
				else
					send_byte_message();
			end
			phase++;
		end

		// ---- wind down ----
		stall_pct = 0;
		drain();
		repeat (8) @(posedge clk);  // catch stray words past the last one
		if (fails == 0 && outstanding == 0)
			$display("base64_stream_codec_unit regression: pass");
		else
			$display("base64_stream_codec_unit regression: fail");
		$finish;
	end

endmodule

FILE: sim.f
design/b64sc_pkg.sv
design/b64sc_if.sv
design/b64sc_front.sv
design/b64sc_queue.sv
design/b64sc_back.sv
design/base64_stream_codec_unit.sv
verif/b64sc_checker.sv
verif/tb_base64_stream_codec_unit.sv
